@@ design/twrtc_pkg.sv @@
// shared types, codes and constants for the three-wire rtc serial master
// no dependencies
`timescale 1ns / 1ps

package twrtc_pkg;

    // default number of bytes in a clock burst
    localparam int DEF_BURST_BYTES = 7;

    // action codes of an input item
    localparam logic [2:0] ACT_TICK        = 3'd0;
    localparam logic [2:0] ACT_READ        = 3'd1;
    localparam logic [2:0] ACT_WRITE       = 3'd2;
    localparam logic [2:0] ACT_BURST_READ  = 3'd3;
    localparam logic [2:0] ACT_BURST_WRITE = 3'd4;
    localparam logic [2:0] ACT_LOAD        = 3'd5;

    // configuration register indexes
    localparam logic REG_HALF_BIT = 1'b0;
    localparam logic REG_SETUP    = 1'b1;

    // register reset values
    localparam logic [7:0] HALF_BIT_RESET = 8'd1;
    localparam logic [7:0] SETUP_RESET    = 8'd3;

    // command byte composition
    localparam logic [7:0] CMD_READ   = 8'h81;
    localparam logic [7:0] CMD_WRITE  = 8'h80;
    localparam logic [4:0] BURST_ADDR = 5'h1F;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    // pin sequencer phases
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PRE,
        PH_SETUP,
        PH_LOW,
        PH_HIGH
    } phase_t;

    // one result item
    typedef struct packed {
        logic       chip_enable;
        logic       serial_clock;
        logic       io_out;
        logic       io_drive;
        logic       read_valid;
        logic [7:0] read_data;
        logic [2:0] read_index;
        logic       read_last;
        logic       busy_res;
        logic       rejected;
    } res_t;

    // burst buffer write request
    typedef struct packed {
        logic       en;
        logic [4:0] addr;
        logic [7:0] data;
    } buf_wr_t;

endpackage

@@ design/three_wire_rtc_serial_master_core.sv @@
// top level of the three-wire rtc serial master: handshake, configuration, result register
// depends on twrtc_pkg, twrtc_seq and twrtc_buf
`timescale 1ns / 1ps
// the result of an item is registered and appears on the output in the cycle after it is accepted
// throughput: one item per cycle while the output is taken; the result register frees as soon as it is taken
// reset (asynchronous, active low) sets the sequencer idle, half_bit_ticks to 1,
// enable_setup_ticks to 3 and empties the result register; buffer bytes stay undefined

module three_wire_rtc_serial_master_core
    import twrtc_pkg::*;
#(
    parameter int BURST_BYTES = DEF_BURST_BYTES
)
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,

    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] action,
    input  logic [4:0] address,
    input  logic [7:0] write_data,
    input  logic       io_in,

    output logic       out_valid,
    input  logic       out_ready,
    output logic       chip_enable,
    output logic       serial_clock,
    output logic       io_out,
    output logic       io_drive,
    output logic       read_valid,
    output logic [7:0] read_data,
    output logic [2:0] read_index,
    output logic       read_last,
    output logic       busy_res,
    output logic       rejected
);

    localparam int IDX_W = (BURST_BYTES > 1) ? $clog2(BURST_BYTES) : 1;

    logic [7:0]       half_bit_reg;
    logic [7:0]       setup_reg;
    logic             out_valid_reg;
    res_t             res_reg;
    res_t             res;
    logic             step;
    buf_wr_t          buf_wr;
    logic             buf_we;
    logic [IDX_W-1:0] buf_raddr;
    logic [7:0]       buf_rdata;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_bit_reg <= HALF_BIT_RESET;
            setup_reg    <= SETUP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_HALF_BIT: half_bit_reg <= cfg_data;
                REG_SETUP:    setup_reg    <= cfg_data;
                default:      half_bit_reg <= half_bit_reg;
            endcase
        end
    end

    // input accepted whenever the result register is free or being emptied
    assign in_ready = !out_valid_reg || out_ready;
    assign step     = in_valid && in_ready;

    twrtc_seq #(
        .BURST_BYTES (BURST_BYTES),
        .IDX_W       (IDX_W)
    ) u_seq (
        .clk                (clk),
        .rst_n              (rst_n),
        .step               (step),
        .action             (action),
        .address            (address),
        .write_data         (write_data),
        .io_in              (io_in),
        .half_bit_ticks     (half_bit_reg),
        .enable_setup_ticks (setup_reg),
        .buf_rdata          (buf_rdata),
        .buf_raddr          (buf_raddr),
        .buf_wr             (buf_wr),
        .res                (res)
    );

    // write only on an accepted item
    assign buf_we = buf_wr.en && step;

    twrtc_buf #(
        .DATA_W (8),
        .DEPTH  (BURST_BYTES),
        .ADDR_W (IDX_W)
    ) u_buf (
        .clk     (clk),
        .wr_en   (buf_we),
        .wr_addr (buf_wr.addr[IDX_W-1:0]),
        .wr_data (buf_wr.data),
        .rd_addr (buf_raddr),
        .rd_data (buf_rdata)
    );

    // result register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign chip_enable  = res_reg.chip_enable;
    assign serial_clock = res_reg.serial_clock;
    assign io_out       = res_reg.io_out;
    assign io_drive     = res_reg.io_drive;
    assign read_valid   = res_reg.read_valid;
    assign read_data    = res_reg.read_data;
    assign read_index   = res_reg.read_index;
    assign read_last    = res_reg.read_last;
    assign busy_res     = res_reg.busy_res;
    assign rejected     = res_reg.rejected;

endmodule

@@ design/twrtc_buf.sv @@
// generic ram: one write port, one registered read port, width and depth as parameters
// no dependencies
`timescale 1ns / 1ps

module twrtc_buf
#(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 7,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // storage, contents undefined until written
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/twrtc_seq.sv @@
// pin sequencer: command latch, bit timing, shifter and result formation
// depends on twrtc_pkg
`timescale 1ns / 1ps

module twrtc_seq
    import twrtc_pkg::*;
#(
    parameter int BURST_BYTES = DEF_BURST_BYTES,
    parameter int IDX_W       = (BURST_BYTES > 1) ? $clog2(BURST_BYTES) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [2:0]       action,
    input  logic [4:0]       address,
    input  logic [7:0]       write_data,
    input  logic             io_in,
    input  logic [7:0]       half_bit_ticks,
    input  logic [7:0]       enable_setup_ticks,
    input  logic [7:0]       buf_rdata,
    output logic [IDX_W-1:0] buf_raddr,
    output buf_wr_t          buf_wr,
    output res_t             res
);

    localparam int BC_W = $clog2(BURST_BYTES + 3);
    localparam logic [BC_W-1:0] TOT_SINGLE = BC_W'(2);
    localparam logic [BC_W-1:0] TOT_BREAD  = BC_W'(BURST_BYTES + 1);
    localparam logic [BC_W-1:0] TOT_BWRITE = BC_W'(BURST_BYTES + 2);
    localparam logic [BC_W-1:0] BURST_N    = BC_W'(BURST_BYTES);
    localparam logic [5:0]      BURST_6    = 6'(BURST_BYTES);

    phase_t          phase_reg, phase_next;
    logic [7:0]      tick_reg, tick_next;
    logic [7:0]      shift_reg, shift_next;
    logic [3:0]      bit_reg, bit_next;
    logic [BC_W-1:0] byte_reg, byte_next;
    logic [2:0]      mode_reg, mode_next;
    logic [4:0]      addr_reg, addr_next;
    logic [7:0]      data_reg, data_next;

    logic            recv;
    logic            recv_mode;
    logic [BC_W-1:0] total;
    logic [BC_W-1:0] next_byte;
    logic [7:0]      cmd_byte;
    logic [7:0]      follow_byte;
    logic [7:0]      dur_raw;
    logic [7:0]      dur;
    logic [7:0]      tick_inc;
    logic [3:0]      bit_inc;
    logic [5:0]      rx_idx;

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            shift_reg <= '0;
            bit_reg   <= '0;
            byte_reg  <= '0;
            mode_reg  <= '0;
            addr_reg  <= '0;
            data_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            shift_reg <= shift_next;
            bit_reg   <= bit_next;
            byte_reg  <= byte_next;
            mode_reg  <= mode_next;
            addr_reg  <= addr_next;
            data_reg  <= data_next;
        end
    end

    // transaction shape
    assign recv_mode = (mode_reg == ACT_READ) || (mode_reg == ACT_BURST_READ);
    assign recv      = recv_mode && (byte_reg != '0);
    assign next_byte = byte_reg + BC_W'(1);
    assign rx_idx    = 6'(byte_reg) - 6'd1;

    always_comb
    begin
        priority if (mode_reg == ACT_BURST_READ)
            total = TOT_BREAD;
        else if (mode_reg == ACT_BURST_WRITE)
            total = TOT_BWRITE;
        else
            total = TOT_SINGLE;
    end

    // command byte for the first byte of a transaction
    always_comb
    begin
        priority if (mode_reg == ACT_READ)
            cmd_byte = {2'b00, addr_reg, 1'b0} | CMD_READ;
        else if (mode_reg == ACT_WRITE)
            cmd_byte = {2'b00, addr_reg, 1'b0} | CMD_WRITE;
        else if (mode_reg == ACT_BURST_READ)
            cmd_byte = {2'b00, BURST_ADDR, 1'b0} | CMD_READ;
        else
            cmd_byte = {2'b00, BURST_ADDR, 1'b0} | CMD_WRITE;
    end

    // outgoing byte following the current one; buffer entry byte_reg
    // the buffer read is registered, the address holds for the whole current byte
    assign buf_raddr = byte_reg[IDX_W-1:0];

    always_comb
    begin
        priority if (recv_mode)
            follow_byte = '0;
        else if (mode_reg == ACT_WRITE && next_byte == BC_W'(1))
            follow_byte = data_reg;
        else if (mode_reg == ACT_BURST_WRITE && next_byte <= BURST_N)
            follow_byte = buf_rdata;
        else
            follow_byte = '0;
    end

    // half period timing, zero counts as one
    assign dur_raw  = (phase_reg == PH_SETUP) ? enable_setup_ticks : half_bit_ticks;
    assign dur      = (dur_raw == '0) ? 8'd1 : dur_raw;
    assign tick_inc = tick_reg + 8'd1;
    assign bit_inc  = bit_reg + 4'd1;

    // next state, buffer write and result
    always_comb
    begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        shift_next = shift_reg;
        bit_next   = bit_reg;
        byte_next  = byte_reg;
        mode_next  = mode_reg;
        addr_next  = addr_reg;
        data_next  = data_reg;
        buf_wr     = '0;
        res        = '0;

        // pins show the state before the item
        res.chip_enable  = (phase_reg == PH_SETUP) || (phase_reg == PH_LOW)
                           || (phase_reg == PH_HIGH);
        res.serial_clock = (phase_reg == PH_HIGH);
        if ((phase_reg == PH_LOW || phase_reg == PH_HIGH) && !recv)
        begin
            res.io_out   = shift_reg[0];
            res.io_drive = 1'b1;
        end

        priority if (action == ACT_TICK)
        begin
            if (phase_reg != PH_IDLE)
            begin
                tick_next = tick_inc;
                if (tick_inc >= dur)
                begin
                    tick_next = '0;
                    unique case (phase_reg)
                        PH_PRE:
                        begin
                            phase_next = PH_SETUP;
                        end
                        PH_SETUP:
                        begin
                            byte_next  = '0;
                            bit_next   = '0;
                            shift_next = cmd_byte;
                            phase_next = PH_LOW;
                        end
                        PH_LOW:
                        begin
                            if (recv)
                            begin
                                shift_next = {io_in, shift_reg[7:1]};
                            end
                            phase_next = PH_HIGH;
                        end
                        PH_HIGH:
                        begin
                            if (!recv)
                            begin
                                shift_next = {1'b0, shift_reg[7:1]};
                            end
                            bit_next = bit_inc;
                            if (bit_inc >= BITS_PER_BYTE)
                            begin
                                if (recv)
                                begin
                                    res.read_valid = 1'b1;
                                    res.read_data  = shift_reg;
                                    res.read_index = rx_idx[2:0];
                                    res.read_last  = (next_byte == total);
                                    if (rx_idx < BURST_6)
                                    begin
                                        buf_wr.en   = 1'b1;
                                        buf_wr.addr = rx_idx[4:0];
                                        buf_wr.data = shift_reg;
                                    end
                                end
                                if (next_byte >= total)
                                begin
                                    phase_next = PH_IDLE;
                                    bit_next   = '0;
                                end
                                else
                                begin
                                    byte_next  = next_byte;
                                    bit_next   = '0;
                                    shift_next = follow_byte;
                                    phase_next = PH_LOW;
                                end
                            end
                            else
                            begin
                                phase_next = PH_LOW;
                            end
                        end
                        default:
                        begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
            end
        end
        else if (action <= ACT_LOAD)
        begin
            if (phase_reg != PH_IDLE)
            begin
                res.rejected = 1'b1;
            end
            else if (action == ACT_LOAD)
            begin
                if ({1'b0, address} < BURST_6)
                begin
                    buf_wr.en   = 1'b1;
                    buf_wr.addr = address;
                    buf_wr.data = write_data;
                end
            end
            else
            begin
                mode_next  = action;
                addr_next  = address;
                data_next  = write_data;
                byte_next  = '0;
                bit_next   = '0;
                shift_next = '0;
                tick_next  = '0;
                phase_next = PH_PRE;
            end
        end
        else
        begin
            // unused action codes leave everything alone
            phase_next = phase_reg;
        end

        res.busy_res = (phase_next != PH_IDLE);
    end

endmodule
